// ===== hdl/hdfd_pkg.sv =====
// Package for the humidity and temperature frame decoder.
// Holds the frame record type, status codes, CRC-8 step and scaling constants.
// Depends on nothing; used by every module of the decoder.
package hdfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC  = 2'd1;
    localparam logic [1:0] STATUS_HUMID_CRC = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [14:0] TEMP_SPAN    = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET  = 15'd4500;
    localparam logic [13:0] HUMID_SPAN   = 14'd12500;
    localparam logic [13:0] HUMID_OFFSET = 14'd600;
    localparam logic [13:0] HUMID_MAX    = 14'd10000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
    } hdfd_rec_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Exact floor(x / 65535) for x below 65535 * 65536.
    function automatic logic [15:0] div65535(input logic [31:0] x);
        logic [15:0] q0;
        logic [16:0] r0;
        q0 = x[31:16];
        r0 = {1'b0, x[15:0]} + {1'b0, q0};
        if (r0 >= 17'd65535)
            return q0 + 16'd1;
        else
            return q0;
    endfunction

endpackage

// ===== hdl/hdfd_front.sv =====
// Front end of the frame decoder: takes reply bytes, runs the CRC checks
// and assembles raw words, emitting one record per complete frame.
// Depends on hdfd_pkg.
module hdfd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    output logic              rec_valid,
    output hdfd_pkg::hdfd_rec_t rec
);

    localparam logic [2:0] POS_THI  = 3'd0;
    localparam logic [2:0] POS_TLO  = 3'd1;
    localparam logic [2:0] POS_TCRC = 3'd2;
    localparam logic [2:0] POS_HHI  = 3'd3;
    localparam logic [2:0] POS_HLO  = 3'd4;
    localparam logic [2:0] POS_HCRC = 3'd5;

    logic [2:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic        tbad_reg, tbad_next;
    logic [15:0] temp_raw_reg, temp_raw_next;
    logic [15:0] humid_raw_reg, humid_raw_next;
    logic        accept;
    logic [1:0]  status;

    assign accept  = in_valid && in_ready;
    assign pos_eff = (frame_start || pos_reg > POS_HCRC) ? POS_THI : pos_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        tbad_next      = tbad_reg;
        temp_raw_next  = temp_raw_reg;
        humid_raw_next = humid_raw_reg;
        if (tbad_reg && pos_eff == POS_HCRC)
            status = hdfd_pkg::STATUS_TEMP_CRC;
        else if (crc_reg != rx_byte)
            status = hdfd_pkg::STATUS_HUMID_CRC;
        else
            status = hdfd_pkg::STATUS_OK;
        if (accept)
        begin
            case (pos_eff)
                POS_THI:
                begin
                    tbad_next           = 1'b0;
                    crc_next            = hdfd_pkg::crc8_step(hdfd_pkg::CRC_INIT, rx_byte);
                    temp_raw_next[15:8] = rx_byte;
                    pos_next            = POS_TLO;
                end
                POS_TLO:
                begin
                    crc_next           = hdfd_pkg::crc8_step(crc_reg, rx_byte);
                    temp_raw_next[7:0] = rx_byte;
                    pos_next           = POS_TCRC;
                end
                POS_TCRC:
                begin
                    tbad_next = (crc_reg != rx_byte);
                    crc_next  = hdfd_pkg::CRC_INIT;
                    pos_next  = POS_HHI;
                end
                POS_HHI:
                begin
                    crc_next             = hdfd_pkg::crc8_step(hdfd_pkg::CRC_INIT, rx_byte);
                    humid_raw_next[15:8] = rx_byte;
                    pos_next             = POS_HLO;
                end
                POS_HLO:
                begin
                    crc_next            = hdfd_pkg::crc8_step(crc_reg, rx_byte);
                    humid_raw_next[7:0] = rx_byte;
                    pos_next            = POS_HCRC;
                end
                default:
                begin
                    crc_next = hdfd_pkg::CRC_INIT;
                    pos_next = POS_THI;
                end
            endcase
        end
    end

    assign rec_valid     = accept && (pos_eff == POS_HCRC);
    assign rec.status    = status;
    assign rec.temp_raw  = temp_raw_reg;
    assign rec.humid_raw = humid_raw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_THI;
            crc_reg  <= hdfd_pkg::CRC_INIT;
            tbad_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            tbad_reg <= tbad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_raw_reg  <= temp_raw_next;
        humid_raw_reg <= humid_raw_next;
    end

endmodule

// ===== hdl/hdfd_queue.sv =====
// Short first-in first-out queue of frame records between front and back end.
// Depends on hdfd_pkg for the record type.
module hdfd_queue
#(
    parameter int DEPTH = hdfd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hdfd_pkg::hdfd_rec_t push_rec,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop,
    output hdfd_pkg::hdfd_rec_t pop_rec
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hdfd_pkg::hdfd_rec_t data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = data_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// ===== hdl/hdfd_back.sv =====
// Back end of the frame decoder: scales raw words to hundredths in two
// registered stages (constant multiply, then divide, offset and clamp);
// a record with a CRC error gives zero values. Depends on hdfd_pkg.
module hdfd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hdfd_pkg::hdfd_rec_t in_rec,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [14:0]         temp_centi,
    output logic [13:0]         humid_centi
);

    logic        s1_valid_reg;
    logic [1:0]  s1_status_reg;
    logic [30:0] s1_tprod_reg, s1_tprod_next;
    logic [29:0] s1_hprod_reg, s1_hprod_next;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [14:0] out_temp_reg, out_temp_next;
    logic [13:0] out_humid_reg, out_humid_next;
    logic        out_advance, s1_load;
    logic [15:0] tq, hq;
    logic [13:0] hdiff;

    assign out_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !s1_valid_reg || out_advance;
    assign s1_load     = in_valid && in_ready;

    assign s1_tprod_next = 31'(hdfd_pkg::TEMP_SPAN) * 31'(in_rec.temp_raw);
    assign s1_hprod_next = 30'(hdfd_pkg::HUMID_SPAN) * 30'(in_rec.humid_raw);

    assign tq    = hdfd_pkg::div65535(32'(s1_tprod_reg));
    assign hq    = hdfd_pkg::div65535(32'(s1_hprod_reg));
    assign hdiff = hq[13:0] - hdfd_pkg::HUMID_OFFSET;

    always_comb
    begin
        if (s1_status_reg != hdfd_pkg::STATUS_OK)
        begin
            out_temp_next  = '0;
            out_humid_next = '0;
        end
        else
        begin
            out_temp_next = tq[14:0] - hdfd_pkg::TEMP_OFFSET;
            if (hq[13:0] < hdfd_pkg::HUMID_OFFSET)
                out_humid_next = '0;
            else if (hdiff > hdfd_pkg::HUMID_MAX)
                out_humid_next = hdfd_pkg::HUMID_MAX;
            else
                out_humid_next = hdiff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= 1'b1;
            else if (out_advance)
                s1_valid_reg <= 1'b0;
            if (out_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_status_reg <= in_rec.status;
            s1_tprod_reg  <= s1_tprod_next;
            s1_hprod_reg  <= s1_hprod_next;
        end
        if (out_advance)
        begin
            out_status_reg <= s1_status_reg;
            out_temp_reg   <= out_temp_next;
            out_humid_reg  <= out_humid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign temp_centi  = out_temp_reg;
    assign humid_centi = out_humid_reg;

endmodule

// ===== hdl/humidity_temp_frame_decoder_unit.sv =====
// Top level of the humidity and temperature frame decoder.
// Depends on hdfd_pkg, hdfd_front, hdfd_queue and hdfd_back.
//
// Usage: reply bytes arrive on the slave stream, one byte per transfer, in
// frame order: temperature high, low, CRC, then humidity high, low, CRC.
// s_axis_tuser marks the first byte of a frame and drops any partial frame;
// without it the position wraps after the sixth byte. Each CRC is CRC-8,
// polynomial 0x31, initial value 0xFF, over its two data bytes.
// After the sixth byte one result leaves on the master stream: status in
// m_axis_tuser, temperature and humidity in hundredths in m_axis_tdata.
// Throughput is one byte per cycle while the queue is not full. After the
// sixth byte's transfer the frame record is registered in the queue, then
// after the constant multiply, then after the divide by 65535, offset and
// clamp. Frame records wait in a queue of QUEUE_DEPTH entries; s_axis_tready
// falls only when it is full, only after the receiver held m_axis_tready low.
// Reset empties the queue and pipeline and returns to the first byte
// position with the CRC at its initial value.
module humidity_temp_frame_decoder_unit
#(
    parameter int QUEUE_DEPTH = hdfd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic        s_axis_tuser,  // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [14:0] temp_centi, [28:15] humid_centi, rest zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    hdfd_pkg::hdfd_rec_t push_rec, pop_rec;
    logic        push, full, pop_valid, pop;
    logic [14:0] temp_centi;
    logic [13:0] humid_centi;

    assign s_axis_tready = !full;

    hdfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .rec_valid   (push),
        .rec         (push_rec)
    );

    hdfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_rec   (pop_rec)
    );

    hdfd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pop_valid),
        .in_ready    (pop),
        .in_rec      (pop_rec),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (m_axis_tuser),
        .temp_centi  (temp_centi),
        .humid_centi (humid_centi)
    );

    assign m_axis_tdata = {3'b000, humid_centi, temp_centi};

endmodule
